FILE: hw/rtl/pbpg_pkg.sv
// Shared types and constants of the proximity beep pattern generator.
// No dependencies; imported by the controller, the datapath and the top level.
package pbpg_pkg;

    localparam int FREQ_W      = 17;
    localparam int STRENGTH_W  = 7;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 16;
    localparam int RATE_W      = 10;   // clamped rate, 1..510
    localparam int REM_W       = RATE_W + 1;
    localparam int DIV_STEPS   = 16;   // one quotient bit per step
    localparam int ITER_W      = $clog2(DIV_STEPS);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ON_TICKS  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_SCALE = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_MIN  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_MAX  = 8'd3;

    // register reset values
    localparam logic [15:0] ON_TICKS_RST  = 16'd250;
    localparam logic [15:0] OFF_SCALE_RST = 16'd50000;
    localparam logic [7:0]  RATE_MIN_RST  = 8'd5;
    localparam logic [7:0]  RATE_MAX_RST  = 8'd30;

    // strength arithmetic
    localparam logic [FREQ_W-1:0]     FREQ_REF     = 17'd10000;
    localparam logic [13:0]           D_SATURATE   = 14'd30;
    localparam logic [STRENGTH_W-1:0] STRENGTH_MAX = 7'd100;
    localparam logic [9:0]            RECIP3       = 10'd683;   // 2^11 / 3, rounded up
    localparam logic [12:0]           RECIP50      = 13'd5243;  // 2^18 / 50, rounded up

    typedef enum logic [2:0] {
        S_IDLE,
        S_STRENGTH,
        S_PROD,
        S_QMAG,
        S_RATE,
        S_DIV,
        S_COMMIT
    } t_state;

    typedef struct packed {
        logic load_in;
        logic calc_strength;
        logic calc_prod;
        logic calc_qmag;
        logic calc_rate;
        logic div_step;
        logic commit;
    } t_dp_cmd;

endpackage

FILE: hw/rtl/pbpg_ctrl.sv
// Sequencer of the beep pattern generator: input/output beats and the
// step commands to the datapath. Depends on pbpg_pkg.
module pbpg_ctrl
    import pbpg_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    output logic    o_valid,
    input  logic    i_stall,
    output t_dp_cmd o_cmd
);

    t_state            r_state, n_state;
    logic [ITER_W-1:0] r_iter, n_iter;
    logic              r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_iter      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_iter      <= n_iter;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        n_iter  = r_iter;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_STRENGTH;
                end
            end
            S_STRENGTH: begin
                o_cmd.calc_strength = 1'b1;
                n_state             = S_PROD;
            end
            S_PROD: begin
                o_cmd.calc_prod = 1'b1;
                n_state         = S_QMAG;
            end
            S_QMAG: begin
                o_cmd.calc_qmag = 1'b1;
                n_state         = S_RATE;
            end
            S_RATE: begin
                o_cmd.calc_rate = 1'b1;
                n_iter          = '0;
                n_state         = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_iter         = r_iter + 1'b1;
                if (r_iter == ITER_W'(DIV_STEPS - 1)) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                // hold until the output register is free
                if (!r_out_valid || !i_stall) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

endmodule

FILE: hw/rtl/pbpg_dp.sv
// Datapath of the beep pattern generator: config registers, strength and
// rate arithmetic, serial divider, tick state and result register. Uses pbpg_pkg.
module pbpg_dp
    import pbpg_pkg::*;
#(
    parameter int TICK_COUNT_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    input  logic [FREQ_W-1:0]     i_frequency,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_speaker,
    output logic                  o_sounding,
    output logic [STRENGTH_W-1:0] o_strength
);

    localparam int CMP_W = (TICK_COUNT_BITS > 16) ? TICK_COUNT_BITS : 16;

    logic [15:0] r_on_ticks, r_off_scale;
    logic [7:0]  r_rate_min, r_rate_max;

    logic [FREQ_W-1:0]       r_freq;
    logic [STRENGTH_W-1:0]   r_strength;
    logic signed [16:0]      r_prod;
    logic [8:0]              r_qmag;
    logic                    r_neg;
    logic [RATE_W-1:0]       r_rate;
    logic [REM_W-1:0]        r_rem;
    logic [15:0]             r_quo;

    logic                       r_phase_snd;
    logic [TICK_COUNT_BITS-1:0] r_tick;
    logic                       r_spk;
    logic                       r_out_spk, r_out_snd;
    logic [STRENGTH_W-1:0]      r_out_str;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on_ticks  <= ON_TICKS_RST;
            r_off_scale <= OFF_SCALE_RST;
            r_rate_min  <= RATE_MIN_RST;
            r_rate_max  <= RATE_MAX_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ON_TICKS:  r_on_ticks  <= i_cfg_data;
                REG_OFF_SCALE: r_off_scale <= i_cfg_data;
                REG_RATE_MIN:  r_rate_min  <= i_cfg_data[7:0];
                REG_RATE_MAX:  r_rate_max  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // strength: d*100/30 == d*10/3, only needed for d below 30
    logic [13:0]           d_full;
    logic [4:0]            d_small;
    logic [8:0]            d_x10;
    logic [17:0]           d_prod;
    logic [STRENGTH_W-1:0] n_strength;

    always_comb begin
        d_full  = 14'(FREQ_REF - r_freq);
        d_small = d_full[4:0];
        d_x10   = {1'b0, d_small, 3'b000} + {3'b000, d_small, 1'b0};
        d_prod  = 18'(d_x10 * RECIP3);
        if (r_freq > FREQ_REF) begin
            n_strength = '0;
        end else if (d_full >= D_SATURATE) begin
            n_strength = STRENGTH_MAX;
        end else begin
            n_strength = d_prod[17:11];
        end
    end

    // rate = rate_min + slope*strength/50, truncated toward zero, floor at 1
    logic signed [8:0]  slope;
    logic [15:0]        prod_mag;
    logic [27:0]        q_prod;
    logic signed [10:0] rate_sum;

    always_comb begin
        slope    = $signed({1'b0, r_rate_max}) - $signed({1'b0, r_rate_min});
        prod_mag = r_prod[16] ? 16'(-r_prod) : r_prod[15:0];
        q_prod   = 28'(prod_mag[14:0] * RECIP50);
        if (r_neg) begin
            rate_sum = $signed({3'b000, r_rate_min}) - $signed({2'b00, r_qmag});
        end else begin
            rate_sum = $signed({3'b000, r_rate_min}) + $signed({2'b00, r_qmag});
        end
    end

    // restoring divider step
    logic [REM_W-1:0] div_trial;
    assign div_trial = {r_rem[REM_W-2:0], r_quo[15]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_freq <= i_frequency;
        end
        if (i_cmd.calc_strength) begin
            r_strength <= n_strength;
        end
        if (i_cmd.calc_prod) begin
            r_prod <= 17'(slope * $signed({1'b0, r_strength}));
        end
        if (i_cmd.calc_qmag) begin
            r_qmag <= q_prod[26:18];
            r_neg  <= r_prod[16];
        end
        if (i_cmd.calc_rate) begin
            r_rate <= (rate_sum < 11'sd1) ? RATE_W'(1) : rate_sum[RATE_W-1:0];
            r_rem  <= '0;
            r_quo  <= r_off_scale;
        end
        if (i_cmd.div_step) begin
            if (div_trial >= {1'b0, r_rate}) begin
                r_rem <= div_trial - {1'b0, r_rate};
                r_quo <= {r_quo[14:0], 1'b1};
            end else begin
                r_rem <= div_trial;
                r_quo <= {r_quo[14:0], 1'b0};
            end
        end
    end

    // tick state update
    logic [TICK_COUNT_BITS-1:0] tick_inc;
    logic [15:0]                limit;
    logic                       phase_end;

    always_comb begin
        tick_inc  = r_tick + 1'b1;
        limit     = r_phase_snd ? r_on_ticks : r_quo;
        phase_end = CMP_W'(tick_inc) >= CMP_W'(limit);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_snd <= 1'b1;
            r_tick      <= '0;
            r_spk       <= 1'b0;
        end else if (i_cmd.commit) begin
            r_spk       <= r_phase_snd ? ~r_spk : 1'b0;
            r_tick      <= phase_end ? '0 : tick_inc;
            r_phase_snd <= phase_end ? ~r_phase_snd : r_phase_snd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_spk <= r_phase_snd ? ~r_spk : 1'b0;
            r_out_snd <= r_phase_snd;
            r_out_str <= r_strength;
        end
    end

    assign o_speaker  = r_out_spk;
    assign o_sounding = r_out_snd;
    assign o_strength = r_out_str;

endmodule

FILE: hw/rtl/proximity_beep_pattern_generator.sv
// Top level of the proximity beep pattern generator.
// Instantiates pbpg_ctrl and pbpg_dp; uses pbpg_pkg.

// One input beat is one timer tick with the latest detector frequency; each
// tick yields one result beat (speaker level, phase, strength). After
// acceptance a tick passes the strength and beep rate steps, the bit-serial
// division off_scale/rate and a commit that updates the phase state, then
// returns to idle. The result waits in an output register, so the next tick
// is taken while it is still stalled. The configuration port is always
// ready; write it only while no tick is in work.
module proximity_beep_pattern_generator
    import pbpg_pkg::*;
#(
    parameter int TICK_COUNT_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [FREQ_W-1:0]     i_frequency,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_speaker,
    output logic                  o_sounding,
    output logic [STRENGTH_W-1:0] o_strength,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd cmd;

    assign o_cfg_ready = 1'b1;

    pbpg_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (cmd)
    );

    pbpg_dp #(
        .TICK_COUNT_BITS (TICK_COUNT_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_frequency (i_frequency),
        .i_cfg_we    (i_cfg_valid & o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_speaker   (o_speaker),
        .o_sounding  (o_sounding),
        .o_strength  (o_strength)
    );

endmodule
